/* rtl/bmp_stream_to_framebuffer_macros.svh */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_TO_FRAMEBUFFER_MACROS_SVH
`define BMP_STREAM_TO_FRAMEBUFFER_MACROS_SVH

// same-cycle implication
`define BSF_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication
`define BSF_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

/* rtl/bsf_pkg.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer package
// Shared constants, codes and the job record passed from parser to writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsf_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 128;

    localparam logic [2:0] ST_PIXEL    = 3'd0;
    localparam logic [2:0] ST_NO_TAG   = 3'd1;
    localparam logic [2:0] ST_TOO_BIG  = 3'd2;
    localparam logic [2:0] ST_BAD_BPP  = 3'd3;
    localparam logic [2:0] ST_BAD_MASK = 3'd4;
    localparam logic [2:0] ST_BAD_COMP = 3'd5;
    localparam logic [2:0] ST_BPP24    = 3'd6;

    localparam logic [1:0] DM_BAD = 2'd0;
    localparam logic [1:0] DM_1   = 2'd1;
    localparam logic [1:0] DM_16  = 2'd2;
    localparam logic [1:0] DM_24  = 2'd3;

    localparam logic [1:0] CM_PLAIN = 2'd0;
    localparam logic [1:0] CM_BITF  = 2'd1;
    localparam logic [1:0] CM_OTHER = 2'd2;

    localparam logic [0:0] CFG_SET_COLOR   = 1'b0;
    localparam logic [0:0] CFG_CLEAR_COLOR = 1'b1;

    localparam logic [15:0] BM_TAG = 16'h424D;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [15:0] color;
        logic [7:0]  bits;
        logic [3:0]  cnt;
        logic        mono;
    } t_job;

    function automatic logic [31:0] mask_expect(input logic [1:0] wi);
        case (wi)
            2'd0:    mask_expect = 32'h0000F800;
            2'd1:    mask_expect = 32'h000007E0;
            2'd2:    mask_expect = 32'h0000001F;
            default: mask_expect = 32'h00000000;
        endcase
    endfunction

endpackage

/* rtl/bsf_front.sv */
// ----------------------------------------------------------------------------
// BMP parser front end
// Parses header, palette and masks; turns pixel bytes into write jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_data_byte,
    input  logic           i_file_start,
    output logic           o_push,
    output bsf_pkg::t_job  o_job
);

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_PALETTE = 5'b00010,
        PH_MASK    = 5'b00100,
        PH_PIXELS  = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

    localparam logic [8:0] DW = 9'(bsf_pkg::DISPLAY_WIDTH);
    localparam logic [8:0] DH = 9'(bsf_pkg::DISPLAY_HEIGHT);

    t_phase      r_phase, n_phase;
    logic [6:0]  r_pos, n_pos;
    logic [31:0] r_fa, n_fa;
    logic [7:0]  r_w, n_w, r_h, n_h, r_rows, n_rows, r_lo, n_lo;
    logic [1:0]  r_dm, n_dm, r_cm, n_cm;
    logic        r_inv, n_inv, r_mgood, n_mgood, r_tag, n_tag, r_sbad, n_sbad;
    logic [8:0]  r_k, n_k;

    logic [2:0]  err;
    logic [8:0]  stride, used, k8, rem, ox, oy, rowv;
    logic [15:0] bits16;
    logic [7:0]  v, hi8, lo8;
    logic [6:0]  mpos;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_fa = r_fa; n_w = r_w; n_h = r_h;
        n_rows = r_rows; n_lo = r_lo; n_dm = r_dm; n_cm = r_cm; n_inv = r_inv;
        n_mgood = r_mgood; n_tag = r_tag; n_sbad = r_sbad; n_k = r_k;
        o_push = 1'b0;
        o_job = '0;
        err = bsf_pkg::ST_PIXEL;
        stride = '0; used = '0; k8 = '0; rem = '0; bits16 = '0;
        v = '0; hi8 = '0; lo8 = '0; mpos = '0;
        ox = (DW - {1'b0, r_w}) >> 1;
        oy = (DH - {1'b0, r_h}) >> 1;
        rowv = {1'b0, r_h} - 9'd1 - {1'b0, r_rows} + oy;
        if (i_take) begin
            if (i_file_start) begin
                n_phase = PH_HEADER; n_pos = '0; n_fa = '0; n_w = '0; n_h = '0;
                n_rows = '0; n_lo = '0; n_dm = bsf_pkg::DM_BAD;
                n_cm = bsf_pkg::CM_PLAIN; n_inv = 1'b0; n_mgood = 1'b1;
                n_tag = 1'b0; n_sbad = 1'b0; n_k = '0;
            end
            case (n_phase)
                PH_HEADER: begin
                    n_fa = {i_data_byte, n_fa[31:8]};
                    case (n_pos)
                        7'd1:  n_tag = ({n_fa[23:16], n_fa[31:24]} == bsf_pkg::BM_TAG);
                        7'd21: begin
                            if (n_fa > 32'(bsf_pkg::DISPLAY_WIDTH)) begin
                                n_sbad = 1'b1; n_w = 8'(bsf_pkg::DISPLAY_WIDTH);
                            end else begin
                                n_w = n_fa[7:0];
                            end
                        end
                        7'd25: begin
                            if (n_fa > 32'(bsf_pkg::DISPLAY_HEIGHT)) begin
                                n_sbad = 1'b1; n_h = 8'(bsf_pkg::DISPLAY_HEIGHT);
                            end else begin
                                n_h = n_fa[7:0];
                            end
                        end
                        7'd29: begin
                            bits16 = n_fa[31:16];
                            n_dm = (bits16 == 16'd1)  ? bsf_pkg::DM_1  :
                                   (bits16 == 16'd16) ? bsf_pkg::DM_16 :
                                   (bits16 == 16'd24) ? bsf_pkg::DM_24 : bsf_pkg::DM_BAD;
                        end
                        7'd33: n_cm = (n_fa == 32'd0) ? bsf_pkg::CM_PLAIN :
                                      (n_fa == 32'h0003) ? bsf_pkg::CM_BITF :
                                      bsf_pkg::CM_OTHER;
                        7'd53: begin
                            if (!n_tag) err = bsf_pkg::ST_NO_TAG;
                            else if (n_sbad) err = bsf_pkg::ST_TOO_BIG;
                            else if (n_dm == bsf_pkg::DM_BAD) err = bsf_pkg::ST_BAD_BPP;
                            else if (n_dm == bsf_pkg::DM_24) err = bsf_pkg::ST_BPP24;
                            else if (n_dm == bsf_pkg::DM_1) n_phase = PH_PALETTE;
                            else if (n_cm == bsf_pkg::CM_PLAIN) begin
                                n_rows = '0; n_k = '0;
                                n_phase = (n_w == 8'd0 || n_h == 8'd0) ? PH_DONE : PH_PIXELS;
                            end else if (n_cm == bsf_pkg::CM_BITF) n_phase = PH_MASK;
                            else err = bsf_pkg::ST_BAD_COMP;
                        end
                        default: ;
                    endcase
                    n_pos = n_pos + 7'd1;
                end
                PH_PALETTE: begin
                    if (n_pos == 7'd54) n_inv = (i_data_byte == 8'd0);
                    n_pos = n_pos + 7'd1;
                    if (n_pos >= 7'd62) begin
                        n_rows = '0; n_k = '0;
                        n_phase = (n_w == 8'd0 || n_h == 8'd0) ? PH_DONE : PH_PIXELS;
                    end
                end
                PH_MASK: begin
                    n_fa = {i_data_byte, n_fa[31:8]};
                    mpos = n_pos - 7'd57;
                    if (n_pos >= 7'd57 && mpos[1:0] == 2'd0) begin
                        if (n_fa != bsf_pkg::mask_expect(mpos[3:2])) n_mgood = 1'b0;
                    end
                    if (n_pos >= 7'd69) begin
                        if (!n_mgood) err = bsf_pkg::ST_BAD_MASK;
                        else begin
                            n_rows = '0; n_k = '0;
                            n_phase = (n_w == 8'd0 || n_h == 8'd0) ? PH_DONE : PH_PIXELS;
                        end
                    end
                    n_pos = n_pos + 7'd1;
                end
                PH_PIXELS: begin
                    o_job.row = rowv[6:0];
                    o_job.status = bsf_pkg::ST_PIXEL;
                    if (n_dm == bsf_pkg::DM_1) begin
                        stride = ((({1'b0, n_w} + 9'd31) >> 5) << 2);
                        used = ({1'b0, n_w} + 9'd7) >> 3;
                        if (n_k < used) begin
                            k8 = n_k << 3;
                            rem = {1'b0, n_w} - k8;
                            v = n_inv ? ~i_data_byte : i_data_byte;
                            o_push = 1'b1;
                            o_job.mono = 1'b1;
                            o_job.bits = v;
                            o_job.cnt = (rem >= 9'd8) ? 4'd8 : rem[3:0];
                            o_job.col = 7'(ox + k8);
                        end
                    end else begin
                        stride = ((({1'b0, n_w} + 9'd1) >> 1) << 2);
                        used = {n_w, 1'b0};
                        if (n_k < used) begin
                            if (!n_k[0]) n_lo = i_data_byte;
                            else begin
                                if (n_cm == bsf_pkg::CM_PLAIN) begin
                                    hi8 = {i_data_byte[6:0], n_lo[7]};
                                    lo8 = {n_lo[6:5], n_lo[5], n_lo[4:0]};
                                end else begin
                                    hi8 = i_data_byte; lo8 = n_lo;
                                end
                                o_push = 1'b1;
                                o_job.color = {hi8, lo8};
                                o_job.cnt = 4'd1;
                                o_job.col = 7'(ox + (n_k >> 1));
                            end
                        end
                    end
                    n_k = n_k + 9'd1;
                    if (n_k >= stride) begin
                        n_k = '0;
                        n_rows = n_rows + 8'd1;
                        if (n_rows >= n_h) n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
            if (err != bsf_pkg::ST_PIXEL) begin
                o_push = 1'b1;
                o_job = '0;
                o_job.status = err;
                o_job.cnt = 4'd1;
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_pos <= '0; r_fa <= '0; r_w <= '0; r_h <= '0;
            r_rows <= '0; r_lo <= '0; r_dm <= bsf_pkg::DM_BAD;
            r_cm <= bsf_pkg::CM_PLAIN; r_inv <= 1'b0; r_mgood <= 1'b1;
            r_tag <= 1'b0; r_sbad <= 1'b0; r_k <= '0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_fa <= n_fa; r_w <= n_w; r_h <= n_h;
            r_rows <= n_rows; r_lo <= n_lo; r_dm <= n_dm; r_cm <= n_cm; r_inv <= n_inv;
            r_mgood <= n_mgood; r_tag <= n_tag; r_sbad <= n_sbad; r_k <= n_k;
        end
    end

endmodule

/* rtl/bsf_fifo.sv */
// ----------------------------------------------------------------------------
// BMP job queue
// Two-entry queue decoupling the parser from the pixel writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bmp_stream_to_framebuffer_macros.svh"

module bsf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsf_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bsf_pkg::t_job  o_head
);

    bsf_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    `BSF_ASSERT_NOW(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2, "queue count overflow")
    `BSF_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, o_full, !i_push, "push into full queue")
    `BSF_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, o_empty, !i_pop, "pop from empty queue")

endmodule

/* rtl/bsf_back.sv */
// ----------------------------------------------------------------------------
// BMP pixel writer back end
// Expands queued jobs into one write per cycle when not stalled; holds colors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bmp_stream_to_framebuffer_macros.svh"

module bsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_empty,
    input  bsf_pkg::t_job  i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [2:0]     o_status,
    output logic [6:0]     o_pixel_row,
    output logic [6:0]     o_pixel_column,
    output logic [15:0]    o_pixel_color,
    output logic           o_run_last
);

    logic [15:0] r_set, r_clr;
    logic [2:0]  r_t;
    logic        r_valid;
    logic        emit, last, bitv;

    assign emit  = !i_empty && (!r_valid || i_out_ready);
    assign last  = !i_head.mono || ({1'b0, r_t} == i_head.cnt - 4'd1);
    assign bitv  = i_head.bits[3'd7 - r_t];
    assign o_pop = emit && last;
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= 16'd0; r_clr <= 16'd2047;
        end else if (i_cfg_we && i_cfg_index[1] == 1'b0) begin
            if (i_cfg_index[0] == bsf_pkg::CFG_SET_COLOR) r_set <= i_cfg_data;
            else r_clr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_t <= '0;
        end else begin
            if (emit) r_valid <= 1'b1;
            else if (i_out_ready) r_valid <= 1'b0;
            if (o_pop) r_t <= '0;
            else if (emit) r_t <= r_t + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_status       <= i_head.status;
            o_pixel_row    <= i_head.row;
            o_pixel_column <= i_head.col + 7'(r_t);
            o_pixel_color  <= i_head.mono ? (bitv ? r_set : r_clr) : i_head.color;
            o_run_last     <= last;
        end
    end

    `BSF_ASSERT_NOW(a_err_last, i_clk, i_rst_n, r_valid && o_status != bsf_pkg::ST_PIXEL, o_run_last, "error result not last")
    `BSF_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_valid && o_status != bsf_pkg::ST_PIXEL, o_pixel_column == 7'd0 && o_pixel_color == 16'd0, "error payload nonzero")
    `BSF_ASSERT_NEXT(a_pop_last, i_clk, i_rst_n, o_pop, r_valid && o_run_last, "pop without last result")

endmodule

/* rtl/bmp_stream_to_framebuffer.sv */
// ----------------------------------------------------------------------------
// BMP stream to framebuffer
// Parses a BMP byte stream and emits centred, bottom-up pixel writes.
// ----------------------------------------------------------------------------
// Header, palette, mask and 16-bit pixel bytes are taken one per cycle while
// the job queue is not full; a 1-bit pixel byte yields up to eight writes,
// one per cycle while the output is ready; the writer sets the sustained rate.
// A two-entry job queue lets the parser keep taking bytes while writes drain.
`timescale 1ns / 1ps

module bmp_stream_to_framebuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [6:0]  o_pixel_row,
    output logic [6:0]  o_pixel_column,
    output logic [15:0] o_pixel_color,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    bsf_pkg::t_job job, head;
    logic push, pop, full, empty, take;

    assign o_in_ready  = !full;
    assign o_cfg_ready = 1'b1;
    assign take        = i_in_valid && !full;

    bsf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_data_byte(i_data_byte), .i_file_start(i_file_start),
        .o_push(push), .o_job(job)
    );

    bsf_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_head(head)
    );

    bsf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_empty(empty), .i_head(head), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_pixel_row(o_pixel_row),
        .o_pixel_column(o_pixel_column), .o_pixel_color(o_pixel_color),
        .o_run_last(o_run_last)
    );

endmodule
